// ----- rtl/v3au_pkg.sv -----
// Shared constants, types and helpers of the three-component vector unit.
package v3au_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned OP_BITS    = 4;
  localparam int unsigned PROD_BITS  = 2 * WORD_BITS;
  localparam int unsigned WIDE_BITS  = PROD_BITS + 3;
  localparam int unsigned SQ_BITS    = 2 * WORD_BITS;
  localparam int unsigned NUM_BITS   = WORD_BITS + FRAC_BITS;
  localparam int unsigned SQRT_STEPS = WORD_BITS;
  localparam int unsigned DIV_STEPS  = NUM_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CROSS = 4'd2,
    OP_DOT   = 4'd3,
    OP_SCALE = 4'd4,
    OP_DIV   = 4'd5,
    OP_LSQ   = 4'd6,
    OP_LEN   = 4'd7,
    OP_NORM  = 4'd8
  } op_e;

  typedef struct packed {
    logic [OP_BITS-1:0] op;
    word_t [2:0]        a;
    word_t [2:0]        b;
    word_t              c;
  } in_t;

  // results settled so far
  typedef struct packed {
    logic [OP_BITS-1:0] op;
    word_t [2:0]        r;
    word_t              s;
    logic               ovf;
    logic               dz;
  } meta_t;

  typedef struct packed {
    meta_t              meta;
    word_t [2:0]        a;
    word_t              c;
    logic [SQ_BITS-1:0] rem;
    logic [SQ_BITS-1:0] root;
  } sq_t;

  typedef struct packed {
    meta_t                          meta;
    logic                           use_q;
    logic [2:0]                     neg;
    logic [WORD_BITS-1:0]           den;
    logic [2:0][WORD_BITS-1:0]      rem;
    logic [2:0][NUM_BITS-1:0]       nq;
  } dv_t;

  // {overflow, saturated word}
  function automatic logic [WORD_BITS:0] sat_word(input logic signed [WIDE_BITS-1:0] v);
    logic signed [WIDE_BITS-1:0] hi;
    logic signed [WIDE_BITS-1:0] lo;
    hi = WIDE_BITS'(WORD_MAX);
    lo = WIDE_BITS'(WORD_MIN);
    if (v > hi) begin
      return {1'b1, WORD_MAX};
    end else if (v < lo) begin
      return {1'b1, WORD_MIN};
    end
    return {1'b0, v[WORD_BITS-1:0]};
  endfunction

endpackage

// ----- rtl/v3au_if.sv -----
// Input and output channel interfaces of the vector unit.
interface v3au_in_if;
  import v3au_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_BITS-1:0]  op;
  logic signed [WORD_BITS-1:0] ax;
  logic signed [WORD_BITS-1:0] ay;
  logic signed [WORD_BITS-1:0] az;
  logic signed [WORD_BITS-1:0] bx;
  logic signed [WORD_BITS-1:0] by;
  logic signed [WORD_BITS-1:0] bz;
  logic signed [WORD_BITS-1:0] scalar;
  modport source(output valid, op, ax, ay, az, bx, by, bz, scalar, input ready);
  modport sink(input valid, op, ax, ay, az, bx, by, bz, scalar, output ready);
endinterface

interface v3au_out_if;
  import v3au_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] rx;
  logic signed [WORD_BITS-1:0] ry;
  logic signed [WORD_BITS-1:0] rz;
  logic signed [WORD_BITS-1:0] rs;
  logic                        overflow;
  logic                        div_zero;
  modport source(output valid, rx, ry, rz, rs, overflow, div_zero, input ready);
  modport sink(input valid, rx, ry, rz, rs, overflow, div_zero, output ready);
endinterface

// ----- rtl/v3au_front.sv -----
// Front stages: input register, shared multipliers, differences, sums and saturation.
module v3au_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  v3au_pkg::in_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output v3au_pkg::sq_t   data_o
);
  import v3au_pkg::*;

  typedef struct packed {
    logic [OP_BITS-1:0]         op;
    word_t [2:0]                a;
    word_t                      c;
    logic [5:0][PROD_BITS-1:0]  m;
    word_t [2:0]                rv;
    logic                       ovf;
  } p2_t;

  typedef struct packed {
    logic [OP_BITS-1:0]         op;
    word_t [2:0]                a;
    word_t                      c;
    logic [2:0][PROD_BITS:0]    d;
    word_t [2:0]                rv;
    logic                       ovf;
  } p3_t;

  in_t  s1_q;
  p2_t  s2_d, s2_q;
  p3_t  s3_d, s3_q;
  sq_t  s4_d, s4_q;
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4     = !v4_q || ready_i;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign ready_o = en1;
  assign valid_o = v4_q;
  assign data_o  = s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= data_i;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
  end

  // Stage 2: operand steering into six multipliers, add/sub beside them.
  word_t ax, ay, az, bx, by, bz, cc;
  word_t mx [6];
  word_t my [6];
  logic signed [PROD_BITS-1:0] prod [6];
  logic signed [WORD_BITS:0]   as_sum [3];
  logic [WORD_BITS:0]          as_sat [3];

  always_comb begin
    ax = s1_q.a[0];
    ay = s1_q.a[1];
    az = s1_q.a[2];
    bx = s1_q.b[0];
    by = s1_q.b[1];
    bz = s1_q.b[2];
    cc = s1_q.c;
    unique case (s1_q.op)
      OP_CROSS: begin
        mx = '{ay, by, az, bz, ax, bx};
        my = '{bz, az, bx, ax, by, ay};
      end
      OP_DOT: begin
        mx = '{ax, '0, ay, '0, az, '0};
        my = '{bx, '0, by, '0, bz, '0};
      end
      OP_SCALE: begin
        mx = '{ax, '0, ay, '0, az, '0};
        my = '{cc, '0, cc, '0, cc, '0};
      end
      OP_LSQ, OP_LEN, OP_NORM: begin
        mx = '{ax, '0, ay, '0, az, '0};
        my = '{ax, '0, ay, '0, az, '0};
      end
      default: begin
        mx = '{'0, '0, '0, '0, '0, '0};
        my = '{'0, '0, '0, '0, '0, '0};
      end
    endcase
    for (int k = 0; k < 6; k++) begin
      prod[k]   = $signed(mx[k]) * $signed(my[k]);
      s2_d.m[k] = prod[k];
    end
    s2_d.op  = s1_q.op;
    s2_d.a   = s1_q.a;
    s2_d.c   = s1_q.c;
    s2_d.ovf = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s1_q.op == OP_SUB) begin
        as_sum[i] = $signed({s1_q.a[i][WORD_BITS-1], s1_q.a[i]})
                  - $signed({s1_q.b[i][WORD_BITS-1], s1_q.b[i]});
      end else begin
        as_sum[i] = $signed({s1_q.a[i][WORD_BITS-1], s1_q.a[i]})
                  + $signed({s1_q.b[i][WORD_BITS-1], s1_q.b[i]});
      end
      as_sat[i] = sat_word(WIDE_BITS'(as_sum[i]));
      if (s1_q.op == OP_ADD || s1_q.op == OP_SUB) begin
        s2_d.rv[i] = as_sat[i][WORD_BITS-1:0];
        s2_d.ovf   = s2_d.ovf | as_sat[i][WORD_BITS];
      end else begin
        s2_d.rv[i] = '0;
      end
    end
  end

  // Stage 3: exact product differences (odd products are zero outside cross).
  always_comb begin
    s3_d.op  = s2_q.op;
    s3_d.a   = s2_q.a;
    s3_d.c   = s2_q.c;
    s3_d.rv  = s2_q.rv;
    s3_d.ovf = s2_q.ovf;
    for (int i = 0; i < 3; i++) begin
      s3_d.d[i] = $signed({s2_q.m[2*i][PROD_BITS-1], s2_q.m[2*i]})
                - $signed({s2_q.m[2*i+1][PROD_BITS-1], s2_q.m[2*i+1]});
    end
  end

  // Stage 4: exact sum, floor shift, saturation; sum of squares feeds the root.
  logic signed [WIDE_BITS-1:0] sum3;
  logic signed [WIDE_BITS-1:0] sum_sh;
  logic signed [WIDE_BITS-1:0] comp_sh [3];
  logic [WORD_BITS:0]          comp_sat [3];
  logic [WORD_BITS:0]          sum_sat;

  always_comb begin
    sum3 = WIDE_BITS'($signed(s3_q.d[0])) + WIDE_BITS'($signed(s3_q.d[1]))
         + WIDE_BITS'($signed(s3_q.d[2]));
    sum_sh  = sum3 >>> FRAC_BITS;
    sum_sat = sat_word(sum_sh);
    for (int i = 0; i < 3; i++) begin
      comp_sh[i]  = WIDE_BITS'($signed(s3_q.d[i]) >>> FRAC_BITS);
      comp_sat[i] = sat_word(comp_sh[i]);
    end
    s4_d.a        = s3_q.a;
    s4_d.c        = s3_q.c;
    s4_d.rem      = sum3[SQ_BITS-1:0];
    s4_d.root     = '0;
    s4_d.meta.op  = s3_q.op;
    s4_d.meta.r   = '0;
    s4_d.meta.s   = '0;
    s4_d.meta.ovf = 1'b0;
    s4_d.meta.dz  = 1'b0;
    unique case (s3_q.op)
      OP_ADD, OP_SUB: begin
        s4_d.meta.r   = s3_q.rv;
        s4_d.meta.ovf = s3_q.ovf;
      end
      OP_CROSS, OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          s4_d.meta.r[i] = comp_sat[i][WORD_BITS-1:0];
          s4_d.meta.ovf  = s4_d.meta.ovf | comp_sat[i][WORD_BITS];
        end
      end
      OP_DOT, OP_LSQ: begin
        s4_d.meta.s   = sum_sat[WORD_BITS-1:0];
        s4_d.meta.ovf = sum_sat[WORD_BITS];
      end
      OP_DIV: begin
        if (s3_q.c == '0) begin
          s4_d.meta.dz = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (s3_q.a[i][WORD_BITS-1]) begin
              s4_d.meta.r[i] = WORD_MIN;
            end else if (s3_q.a[i] != '0) begin
              s4_d.meta.r[i] = WORD_MAX;
            end else begin
              s4_d.meta.r[i] = '0;
            end
          end
        end
      end
      // zero-length vector comes back unchanged
      OP_NORM: s4_d.meta.r = s3_q.a;
      default: ;
    endcase
  end

endmodule

// ----- rtl/v3au_sqrt.sv -----
// Floor square root of the 64-bit sum of squares, one result bit per stage.
module v3au_sqrt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  v3au_pkg::sq_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output v3au_pkg::sq_t   data_o
);
  import v3au_pkg::*;

  sq_t                   st_q [SQRT_STEPS];
  sq_t                   st_d [SQRT_STEPS];
  sq_t                   prev [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] pv;
  logic [SQRT_STEPS-1:0] v_q;
  logic [SQRT_STEPS:0]   en;

  assign en[SQRT_STEPS] = ready_i;
  assign ready_o        = en[0];
  assign valid_o        = v_q[SQRT_STEPS-1];
  assign data_o         = st_q[SQRT_STEPS-1];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [SQ_BITS-1:0] RootBit = SQ_BITS'(1) << (SQ_BITS - 2 - 2 * k);
    logic [SQ_BITS-1:0] trial;

    if (k == 0) begin : g_head
      assign prev[k] = data_i;
      assign pv[k]   = valid_i;
    end else begin : g_body
      assign prev[k] = st_q[k-1];
      assign pv[k]   = v_q[k-1];
    end

    assign en[k] = !v_q[k] || en[k+1];

    always_comb begin
      st_d[k] = prev[k];
      trial   = prev[k].root + RootBit;
      if (prev[k].rem >= trial) begin
        st_d[k].rem  = prev[k].rem - trial;
        st_d[k].root = (prev[k].root >> 1) + RootBit;
      end else begin
        st_d[k].root = prev[k].root >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

endmodule

// ----- rtl/v3au_div.sv -----
// Divider setup and restoring division of three components, one quotient bit per stage.
module v3au_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  v3au_pkg::sq_t   data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output v3au_pkg::dv_t   data_o
);
  import v3au_pkg::*;

  localparam int unsigned NST = DIV_STEPS + 1;

  dv_t              st_q [NST];
  dv_t              st_d [NST];
  logic [NST-1:0]   v_q;
  logic [NST-1:0]   pv;
  logic [NST:0]     en;

  assign en[NST]  = ready_i;
  assign ready_o  = en[0];
  assign valid_o  = v_q[NST-1];
  assign data_o   = st_q[NST-1];

  // Setup: length result, divisor choice, operand magnitudes.
  logic [WORD_BITS-1:0] root;
  logic [WORD_BITS-1:0] mag_c;
  logic [WORD_BITS-1:0] mag_a [3];
  logic                 is_div;
  logic                 is_norm;

  always_comb begin
    root    = data_i.root[WORD_BITS-1:0];
    mag_c   = data_i.c[WORD_BITS-1] ? (~data_i.c + 1'b1) : data_i.c;
    is_div  = (data_i.meta.op == OP_DIV);
    is_norm = (data_i.meta.op == OP_NORM);
    st_d[0].meta = data_i.meta;
    if (data_i.meta.op == OP_LEN) begin
      st_d[0].meta.s   = root[WORD_BITS-1] ? WORD_MAX : root;
      st_d[0].meta.ovf = root[WORD_BITS-1];
    end
    st_d[0].den   = is_norm ? root : mag_c;
    st_d[0].use_q = (is_div && data_i.c != '0) || (is_norm && root != '0);
    for (int i = 0; i < 3; i++) begin
      mag_a[i] = data_i.a[i][WORD_BITS-1] ? (~data_i.a[i] + 1'b1) : data_i.a[i];
      st_d[0].neg[i] = data_i.a[i][WORD_BITS-1] ^ (is_div && data_i.c[WORD_BITS-1]);
      st_d[0].rem[i] = '0;
      st_d[0].nq[i]  = {mag_a[i], {FRAC_BITS{1'b0}}};
    end
  end

  assign pv[0] = valid_i;

  for (genvar k = 1; k < NST; k++) begin : g_step
    logic [WORD_BITS:0] t [3];
    logic [2:0]         ge;

    assign pv[k] = v_q[k-1];

    // numerator shifts out the top while quotient bits shift in below
    always_comb begin
      st_d[k] = st_q[k-1];
      for (int i = 0; i < 3; i++) begin
        t[i]  = {st_q[k-1].rem[i], st_q[k-1].nq[i][NUM_BITS-1]};
        ge[i] = (t[i] >= {1'b0, st_q[k-1].den});
        st_d[k].nq[i] = {st_q[k-1].nq[i][NUM_BITS-2:0], ge[i]};
        if (ge[i]) begin
          st_d[k].rem[i] = t[i][WORD_BITS-1:0] - st_q[k-1].den;
        end else begin
          st_d[k].rem[i] = t[i][WORD_BITS-1:0];
        end
      end
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_reg
    assign en[k] = !v_q[k] || en[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en[k]) begin
        v_q[k] <= pv[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

endmodule

// ----- rtl/vector3_arithmetic_unit.sv -----
// Top level of the three-component Q16.16 vector unit.
// Stages from input transfer to result valid: 4 front stages, 32 square-root stages,
// 49 divider stages and 1 output register, the same for every op.
// Throughput: one item per cycle unless stalled; root and divider fully pipelined.
// Stalls propagate stage by stage, so empty stages still accept while a result waits.
// Reset clears all valid bits; datapath registers are not reset.
module vector3_arithmetic_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  v3au_in_if.sink     in_i,
  v3au_out_if.source  out_o
);
  import v3au_pkg::*;

  localparam logic [NUM_BITS-1:0] QMaxPos = NUM_BITS'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam logic [NUM_BITS-1:0] QMaxNeg = NUM_BITS'(1) << (WORD_BITS - 1);

  in_t  in_d;
  sq_t  fr_data, sq_data;
  dv_t  dv_data;
  logic fr_valid, fr_ready, sq_valid, sq_ready, dv_valid, dv_ready;

  always_comb begin
    in_d.op   = in_i.op;
    in_d.a[0] = in_i.ax;
    in_d.a[1] = in_i.ay;
    in_d.a[2] = in_i.az;
    in_d.b[0] = in_i.bx;
    in_d.b[1] = in_i.by;
    in_d.b[2] = in_i.bz;
    in_d.c    = in_i.scalar;
  end

  v3au_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_d),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .data_o  (fr_data)
  );

  v3au_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  (fr_data),
    .valid_o (sq_valid),
    .ready_i (sq_ready),
    .data_o  (sq_data)
  );

  v3au_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_valid),
    .ready_o (sq_ready),
    .data_i  (sq_data),
    .valid_o (dv_valid),
    .ready_i (dv_ready),
    .data_o  (dv_data)
  );

  // Output stage: signed, saturated quotients for divide and normalize.
  word_t [2:0]         r_d, r_q;
  word_t               rs_q;
  logic                ovf_d, ovf_q, dz_q, out_valid_q;
  logic [NUM_BITS-1:0] q_neg [3];

  assign dv_ready = !out_valid_q || out_o.ready;

  always_comb begin
    r_d   = dv_data.meta.r;
    ovf_d = dv_data.meta.ovf;
    for (int i = 0; i < 3; i++) begin
      q_neg[i] = ~dv_data.nq[i] + 1'b1;
      if (dv_data.use_q) begin
        if (dv_data.neg[i]) begin
          if (dv_data.nq[i] > QMaxNeg) begin
            r_d[i] = WORD_MIN;
            ovf_d  = 1'b1;
          end else begin
            r_d[i] = q_neg[i][WORD_BITS-1:0];
          end
        end else begin
          if (dv_data.nq[i] > QMaxPos) begin
            r_d[i] = WORD_MAX;
            ovf_d  = 1'b1;
          end else begin
            r_d[i] = dv_data.nq[i][WORD_BITS-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dv_ready) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready) begin
      r_q   <= r_d;
      rs_q  <= dv_data.meta.s;
      ovf_q <= ovf_d;
      dz_q  <= dv_data.meta.dz;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.rx       = r_q[0];
  assign out_o.ry       = r_q[1];
  assign out_o.rz       = r_q[2];
  assign out_o.rs       = rs_q;
  assign out_o.overflow = ovf_q;
  assign out_o.div_zero = dz_q;

endmodule
